### rtl/dwg_pkg.sv
// ----------------------------------------------------------------------------
// DAC waveform generator package
// Shared widths, command and register codes, and controller types.
// ----------------------------------------------------------------------------
package dwg_pkg;

  localparam int CMD_W   = 3;
  localparam int AMP_W   = 16;
  localparam int WORD_W  = 14;
  localparam int MAXC_W  = 12;
  localparam int STEP_W  = 9;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 12;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DC     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SQUARE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SAW    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRI    = 3'd4;

  localparam logic [CFG_IW-1:0] REG_MAX_CODE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_STEP_COUNT = 2'd1;

  localparam logic [MAXC_W-1:0] MAX_CODE_RST   = 12'hFFF;
  localparam logic [STEP_W-1:0] STEP_COUNT_RST = 9'd64;
  localparam logic [STEP_W-1:0] STEP_MIN       = 9'd2;

  localparam logic [WORD_W-1:0] CTRL_BITS = 14'h3000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_DIRECT,
    KIND_RAMP
  } kind_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  div_last;
    logic  code_new;
    logic  out_free;
  } dp_stat_t;

endpackage

### rtl/dac_waveform_generator.sv
// ----------------------------------------------------------------------------
// DAC waveform generator
// Phase-stepped DC, square, sawtooth and triangle codes as DAC words.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+----------------------------
//  in      | input     | in_valid_i/in_stall_o | in_command_i, in_amplitude_i
//  out     | output    | out_valid_o/out_stall_i | out_dac_word_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A tick or an unused command ends on acceptance; DC and square go on to the
//  emit state; sawtooth and triangle to the multiply, divide and emit states.
//  The restoring divider produces one quotient bit per cycle.
//  Reset is asynchronous and needs no clearing pass.
//  A held result waits in the output register; a new request is taken while
//  it waits, and only emission of the next word stalls behind it.
// ----------------------------------------------------------------------------
module dac_waveform_generator
  import dwg_pkg::*;
#(
  parameter int STEP_MAX  = 256,
  parameter int CODE_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  in_command_i,
  input  logic [AMP_W-1:0]  in_amplitude_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] out_dac_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  dwg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  dwg_dpath #(
    .STEP_MAX  (STEP_MAX),
    .CODE_BITS (CODE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .in_command_i   (in_command_i),
    .in_amplitude_i (in_amplitude_i),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_dac_word_o (out_dac_word_o)
  );

endmodule

### rtl/dwg_ctrl.sv
// ----------------------------------------------------------------------------
// DAC waveform generator controller
// Sequences acceptance, multiplication, division and emission of one request.
// ----------------------------------------------------------------------------
module dwg_ctrl
  import dwg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.kind)
            KIND_RAMP:   state_d = ST_MUL;
            KIND_DIRECT: state_d = ST_EMIT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.code_new || stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.emit      = (state_q == ST_EMIT) && stat_i.code_new && stat_i.out_free;
  end

endmodule

### rtl/dwg_dpath.sv
// ----------------------------------------------------------------------------
// DAC waveform generator datapath
// Holds configuration, phase and last code, and computes codes with a
// multiplier and a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dwg_dpath
  import dwg_pkg::*;
#(
  parameter int STEP_MAX  = 256,
  parameter int CODE_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [CMD_W-1:0]  in_command_i,
  input  logic [AMP_W-1:0]  in_amplitude_i,
  input  logic              cfg_write_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] out_dac_word_o
);

  localparam int SMAX    = (STEP_MAX > 511) ? 511 : STEP_MAX;
  localparam int PHASE_W = (SMAX > 2) ? $clog2(SMAX) : 1;
  localparam int QW      = CODE_BITS;
  localparam int CNT_W   = $clog2(QW);
  localparam int PROD_W  = STEP_W + QW;
  localparam logic [STEP_W-1:0] SMAX_C   = STEP_W'(SMAX);
  localparam logic [QW-1:0]     CODE_MAX = {QW{1'b1}};

  function automatic logic [STEP_W-1:0] sat_steps(input logic [STEP_W-1:0] raw);
    logic [STEP_W-1:0] s;
    s = raw;
    if (raw < STEP_MIN) begin
      s = STEP_MIN;
    end else if (raw > SMAX_C) begin
      s = SMAX_C;
    end
    return s;
  endfunction

  logic [MAXC_W-1:0]  max_code_q;
  logic [STEP_W-1:0]  step_count_q;
  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] phase_d;
  logic [QW-1:0]      last_code_q;
  logic               out_valid_q;
  logic [WORD_W-1:0]  out_word_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [AMP_W-1:0]   amp_q;
  logic [STEP_W-1:0]  rem_q;
  logic [QW-1:0]      quo_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [STEP_W-1:0]  s_eff;
  logic [STEP_W-1:0]  s_new;
  logic [QW-1:0]      m_eff;
  logic [STEP_W:0]    phase_inc;
  logic [STEP_W-1:0]  phase_w;
  logic [STEP_W-1:0]  num;
  logic [PROD_W-1:0]  product;
  logic [STEP_W:0]    shifted;
  logic [STEP_W:0]    diff;
  logic               fits;
  logic               is_ramp;
  logic [AMP_W-1:0]   direct_raw;
  logic [QW-1:0]      direct_code;
  logic [QW-1:0]      code;
  logic               cfg_step;

  assign s_eff    = sat_steps(step_count_q);
  assign s_new    = sat_steps(cfg_data_i[STEP_W-1:0]);
  assign m_eff    = (max_code_q > MAXC_W'(CODE_MAX)) ? CODE_MAX : max_code_q[QW-1:0];
  assign phase_w  = STEP_W'(phase_q);
  assign cfg_step = cfg_write_i && (cfg_index_i == REG_STEP_COUNT);

  assign phase_inc = (STEP_W + 1)'(phase_q) + (STEP_W + 1)'(1);

  always_comb begin
    phase_d = phase_q;
    if (cfg_step) begin
      if (phase_w >= s_new) begin
        phase_d = '0;
      end
    end else if (cmd_i.accept && (in_command_i == CMD_TICK)) begin
      if (phase_inc >= {1'b0, s_eff}) begin
        phase_d = '0;
      end else begin
        phase_d = PHASE_W'(phase_inc);
      end
    end
  end

  assign num = ((cmd_q == CMD_TRI) && (phase_w >= (s_eff >> 1))) ? (s_eff - phase_w)
                                                                  : phase_w;
  assign product = PROD_W'(num) * PROD_W'(m_eff);

  assign shifted = {rem_q, quo_q[QW-1]};
  assign fits    = (shifted >= {1'b0, s_eff});
  assign diff    = shifted - {1'b0, s_eff};

  assign is_ramp     = (cmd_q == CMD_SAW) || (cmd_q == CMD_TRI);
  assign direct_raw  = ((cmd_q == CMD_SQUARE) && !phase_q[0]) ? '0 : amp_q;
  assign direct_code = (direct_raw > AMP_W'(m_eff)) ? m_eff : direct_raw[QW-1:0];
  assign code        = is_ramp ? quo_q : direct_code;

  always_comb begin
    stat_o.div_last = (cnt_q == '0);
    stat_o.code_new = (code != last_code_q);
    stat_o.out_free = !out_valid_q || !out_stall_i;
    unique case (in_command_i)
      CMD_TICK:              stat_o.kind = KIND_TICK;
      CMD_DC, CMD_SQUARE:    stat_o.kind = KIND_DIRECT;
      CMD_SAW, CMD_TRI:      stat_o.kind = KIND_RAMP;
      default:               stat_o.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_code_q   <= MAX_CODE_RST;
      step_count_q <= STEP_COUNT_RST;
      phase_q      <= '0;
      last_code_q  <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cfg_write_i && (cfg_index_i == REG_MAX_CODE)) begin
        max_code_q <= cfg_data_i[MAXC_W-1:0];
      end
      if (cfg_step) begin
        step_count_q <= cfg_data_i[STEP_W-1:0];
      end
      phase_q <= phase_d;
      if (cmd_i.mul) begin
        cnt_q <= CNT_W'(QW - 1);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.emit) begin
        last_code_q <= code;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_command_i;
      amp_q <= in_amplitude_i;
    end
    if (cmd_i.mul) begin
      {rem_q, quo_q} <= product;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
      quo_q <= {quo_q[QW-2:0], fits};
    end
    if (cmd_i.emit) begin
      out_word_q <= CTRL_BITS | WORD_W'(code);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_dac_word_o = out_word_q;

endmodule

### rtl/dwg_checker.sv
// ----------------------------------------------------------------------------
// DAC waveform generator checker
// Port-level properties of the generator, bound to its top level.
// ----------------------------------------------------------------------------
module dwg_assertions
  import dwg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CMD_W-1:0]  in_command_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [WORD_W-1:0] out_dac_word_o
);

  logic in_accept;
  logic in_coded;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_coded  = (in_command_i == CMD_DC) || (in_command_i == CMD_SQUARE) ||
                     (in_command_i == CMD_SAW) || (in_command_i == CMD_TRI);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_dac_word_o))
    else $error("stalled result changed or vanished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_dac_word_o[WORD_W-1:WORD_W-2] == 2'b11))
    else $error("control bits missing from DAC word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !$rose(out_valid_o))
    else $error("result appeared in the cycle after a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_coded |=> in_stall_o)
    else $error("waveform request did not occupy the generator");

endmodule

bind dac_waveform_generator dwg_assertions u_dwg_assertions (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .in_command_i   (in_command_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_dac_word_o (out_dac_word_o)
);

### bench/dwg_checker.sv
// ----------------------------------------------------------------------------
// DAC waveform generator checker
// Watches the request, result and register channels of the generator, keeps
// its own copy of the phase, last code and registers, and compares every DAC
// word that leaves the block with the oldest word still owed.
// ----------------------------------------------------------------------------
module dwg_checker
  import dwg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [CMD_W-1:0]  in_command_i,
  input  logic [AMP_W-1:0]  in_amplitude_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [WORD_W-1:0] out_dac_word_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [STEP_W-1:0] STEP_LIMIT = 9'd256;

  logic [MAXC_W-1:0] max_code_q;
  logic [STEP_W-1:0] step_count_q;
  logic [7:0]        phase_q;
  logic [MAXC_W-1:0] last_code_q;
  logic [CMD_W-1:0]  last_mode_q;
  logic [WORD_W-1:0] owed_words [$];
  logic [WORD_W-1:0] oldest_word;
  int                mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [STEP_W-1:0] steps_in_use(input logic [STEP_W-1:0] raw);
    if (raw < STEP_MIN) begin
      return STEP_MIN;
    end
    if (raw > STEP_LIMIT) begin
      return STEP_LIMIT;
    end
    return raw;
  endfunction

  function automatic logic [MAXC_W-1:0] ramp_code(input logic [STEP_W-1:0] num,
                                                  input logic [STEP_W-1:0] steps);
    logic [31:0] product;
    product = 32'(num) * 32'(max_code_q);
    return MAXC_W'(product / 32'(steps));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("dwg_checker: %s", msg);
  endtask

  task automatic apply_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    case (idx)
      REG_MAX_CODE: begin
        max_code_q = data[MAXC_W-1:0];
      end
      REG_STEP_COUNT: begin
        step_count_q = data[STEP_W-1:0];
        if ({1'b0, phase_q} >= steps_in_use(step_count_q)) begin
          phase_q = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [AMP_W-1:0] amp);
    logic [STEP_W-1:0] steps;
    logic [STEP_W-1:0] wide_phase;
    logic [AMP_W-1:0]  code;
    steps      = steps_in_use(step_count_q);
    wide_phase = {1'b0, phase_q};
    code       = '0;
    case (cmd)
      CMD_TICK: begin
        phase_q = (wide_phase + 9'd1 >= steps) ? 8'd0 : phase_q + 8'd1;
      end
      CMD_DC: begin
        code = amp;
      end
      CMD_SQUARE: begin
        code = phase_q[0] ? amp : '0;
      end
      CMD_SAW: begin
        code = AMP_W'(ramp_code(wide_phase, steps));
      end
      CMD_TRI: begin
        if (wide_phase >= steps / 2) begin
          code = AMP_W'(ramp_code(steps - wide_phase, steps));
        end else begin
          code = AMP_W'(ramp_code(wide_phase, steps));
        end
      end
      default: begin
      end
    endcase
    if (cmd >= CMD_DC && cmd <= CMD_TRI) begin
      last_mode_q = cmd;
      if (code > AMP_W'(max_code_q)) begin
        code = AMP_W'(max_code_q);
      end
      if (code[MAXC_W-1:0] != last_code_q) begin
        last_code_q = code[MAXC_W-1:0];
        owed_words.push_back(CTRL_BITS | WORD_W'(code[MAXC_W-1:0]));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_code_q   = MAX_CODE_RST;
      step_count_q = STEP_COUNT_RST;
      phase_q      = '0;
      last_code_q  = '0;
      last_mode_q  = CMD_TICK;
      owed_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("DAC word 0x%h arrived with no request owing one",
                                    out_dac_word_i));
        end else begin
          oldest_word = owed_words.pop_front();
          if (out_dac_word_i !== oldest_word) begin
            report_mismatch($sformatf("dac_word is 0x%h, expected 0x%h",
                                      out_dac_word_i, oldest_word));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        apply_register(cfg_index_i, cfg_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(in_command_i, in_amplitude_i);
      end
    end
    fail_count_o = mismatches;
    pending_o    = owed_words.size();
  end

endmodule

### bench/dac_waveform_generator_test.sv
// ----------------------------------------------------------------------------
// DAC waveform generator testbench
// Drives directed and random waveform requests and register writes into the
// generator under bursty traffic and receiver back-pressure, while a checker
// beside the block predicts and compares every DAC word.
// ----------------------------------------------------------------------------
module dac_waveform_generator_test;
  import dwg_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IW-1:0] REG_UNUSED_LO    = 2'd2;
  localparam logic [CFG_IW-1:0] REG_UNUSED_HI    = 2'd3;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CMD_W-1:0]  in_command_i;
  logic [AMP_W-1:0]  in_amplitude_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [WORD_W-1:0] out_dac_word_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  int                fail_count;
  int                pending;
  int                hold_off_requests = 0;
  logic              hold_active = 1'b0;
  int                quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  dac_waveform_generator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_command_i   (in_command_i),
    .in_amplitude_i (in_amplitude_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_dac_word_o (out_dac_word_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  dwg_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_command_i   (in_command_i),
    .in_amplitude_i (in_amplitude_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_dac_word_i (out_dac_word_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** dac_waveform_generator: FAILED **");
      $finish;
    end
  end

  // The receiver alternates between stretches of differing stall density, and
  // serves each hold-off request with one long unbroken stall.
  initial begin : receiver
    int served;
    int style;
    int span;
    served      = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_requests > served) begin
        served++;
        hold_active = 1'b1;
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_active = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(4, 60);
        repeat (span) begin
          case (style)
            0: out_stall_i = 1'b0;
            1: out_stall_i = ($urandom_range(0, 3) == 0);
            2: out_stall_i = ($urandom_range(0, 3) != 0);
            default: out_stall_i = ~out_stall_i;
          endcase
          @(negedge clk_i);
        end
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [AMP_W-1:0] amp);
    in_valid_i     = 1'b1;
    in_command_i   = cmd;
    in_amplitude_i = amp;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic settle_idle();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_waveform();
    case ($urandom_range(0, 3))
      0: return CMD_DC;
      1: return CMD_SQUARE;
      2: return CMD_SAW;
      default: return CMD_TRI;
    endcase
  endfunction

  function automatic logic [AMP_W-1:0] pick_amplitude();
    case ($urandom_range(0, 3))
      0: return AMP_W'($urandom);
      1: return AMP_W'($urandom_range(0, 4095));
      2: return AMP_W'($urandom_range(0, 7));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic run_directed();
    send_request(CMD_DC, '0);
    send_request(CMD_DC, 16'hFFFF);
    send_request(CMD_DC, 16'h0800);
    send_request(CMD_DC, 16'h0800);
    send_request(CMD_SQUARE, 16'h7FFF);
    send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_SQUARE, 16'h8001);
    send_request(CMD_SAW, 16'h5555);
    send_request(CMD_TRI, 16'hAAAA);
    send_request(CMD_UNUSED_FIRST, 16'hFFFF);
    send_request(CMD_UNUSED_FIRST + 3'd1, 16'h0000);
    send_request(CMD_UNUSED_FIRST + 3'd2, 16'h1234);
    settle_idle();
    write_register(REG_STEP_COUNT, 12'd4);
    send_request(CMD_TICK, '0);
    send_request(CMD_TRI, '0);
    send_request(CMD_TICK, '0);
    send_request(CMD_SAW, '0);
    send_request(CMD_TRI, '0);
    settle_idle();
    // Step count below the minimum, and below the current phase.
    write_register(REG_STEP_COUNT, 12'h000);
    send_request(CMD_SAW, '0);
    send_request(CMD_TICK, '0);
    send_request(CMD_SAW, '0);
    send_request(CMD_TICK, '0);
    settle_idle();
    write_register(REG_MAX_CODE, 12'h000);
    write_register(REG_UNUSED_LO, 12'hFFF);
    write_register(REG_UNUSED_HI, 12'hFFF);
    send_request(CMD_DC, 16'hFFFF);
    settle_idle();
    write_register(REG_MAX_CODE, 12'hFFF);
    write_register(REG_STEP_COUNT, 12'hFFF);
    send_request(CMD_DC, 16'h0FFF);
    send_request(CMD_SQUARE, 16'h0FFF);
  endtask

  task automatic drive_random_items(input int quota, input int gap_max);
    int sent;
    int burst_left;
    int pick;
    int ticks;
    sent       = 0;
    burst_left = $urandom_range(1, 16);
    while (sent < quota) begin
      if (burst_left == 0) begin
        if (gap_max > 0) begin
          pause_sender($urandom_range(1, gap_max));
        end
        burst_left = $urandom_range(1, 16);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_request(CMD_UNUSED_FIRST + CMD_W'($urandom_range(0, 2)), AMP_W'($urandom));
      end else if (pick < 10) begin
        ticks = $urandom_range(2, 48);
        repeat (ticks) send_request(CMD_TICK, AMP_W'($urandom));
        sent += ticks;
      end else if (pick < 40) begin
        send_request(CMD_TICK, AMP_W'($urandom));
        sent++;
      end else begin
        send_request(pick_waveform(), pick_amplitude());
        sent++;
      end
      burst_left--;
    end
  endtask

  task automatic run_phase(input int p);
    logic [CFG_DW-1:0] max_data;
    logic [CFG_DW-1:0] step_data;
    int gap_max;
    case (p)
      0: begin max_data = 12'hFFF; step_data = 12'd256; end
      1: begin max_data = 12'h000; step_data = 12'd2;   end
      2: begin max_data = 12'hFFF; step_data = 12'd2;   end
      3: begin max_data = 12'h001; step_data = 12'd3;   end
      4: begin max_data = 12'hFFF; step_data = 12'hFFF; end
      5: begin max_data = 12'h800; step_data = 12'd16;  end
      6: begin max_data = CFG_DW'($urandom); step_data = 12'hE00; end
      7: begin max_data = CFG_DW'($urandom); step_data = 12'h201; end
      default: begin
        max_data  = CFG_DW'($urandom);
        step_data = CFG_DW'($urandom);
      end
    endcase
    settle_idle();
    write_register(REG_MAX_CODE, max_data);
    write_register(REG_STEP_COUNT, step_data);
    if ($urandom_range(0, 1) == 1) begin
      write_register($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_DW'($urandom));
    end
    case (p % 3)
      0: gap_max = 0;
      1: gap_max = 4;
      default: gap_max = 16;
    endcase
    if (p == 3) begin
      hold_off_requests++;
      while (!hold_active) @(negedge clk_i);
    end
    if (p == 5) begin
      drive_random_items(38, gap_max);
      wait_for_drain();
      drive_random_items(38, gap_max);
    end else begin
      drive_random_items(76, gap_max);
    end
  endtask

  task automatic run_random_phases();
    int p;
    for (p = 0; p < 10; p++) begin
      run_phase(p);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_command_i   = CMD_TICK;
    in_amplitude_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_MAX_CODE;
    cfg_data_i     = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random_phases();
    settle_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("** dac_waveform_generator: PASSED **");
    end else begin
      $display("** dac_waveform_generator: FAILED **");
    end
    $finish;
  end

endmodule
